@@ src/cwe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cwe_pkg;

   localparam int MAX_WORD_LEN = 8;
   localparam int TABLE_DEPTH  = 256;

   localparam int CharW      = 8;
   localparam int DigitW     = 8;
   localparam int SizeW      = 9;
   localparam int LenW       = 4;
   localparam int CountW     = 40;
   localparam int WordW      = 64;
   localparam int WordBytes  = WordW / CharW;
   localparam int CsrIndexW  = 3;
   localparam int CsrDataW   = 40;

   typedef enum logic [1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_NEXT    = 2'd1,
      FUNC_RESTART = 2'd2
   } func_type;

   localparam logic [CsrIndexW-1:0] CSR_CHARSET_SIZE = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_MIN_LENGTH   = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_MAX_LENGTH   = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_LIMIT_ENABLE = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_LINE_LIMIT   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADV,
      ST_CARRY,
      ST_FILL
   } walk_state_type;

   typedef struct packed {
      logic [1:0]       func;
      logic [DigitW-1:0] entry_index;
      logic [CharW-1:0]  entry_char;
   } req_type;

   typedef struct packed {
      logic [WordW-1:0] word;
      logic [LenW-1:0]  word_len;
      logic             exhausted;
   } rsp_type;

   typedef struct packed {
      logic [SizeW-1:0]  charset_size;
      logic [LenW-1:0]   min_length;
      logic [LenW-1:0]   max_length;
      logic              limit_enable;
      logic [CountW-1:0] line_limit;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [DigitW-1:0] wr_addr;
      logic [CharW-1:0]  wr_data;
      logic              rd_en;
      logic [DigitW-1:0] rd_addr;
   } tbl_req_type;

endpackage

`default_nettype wire

@@ src/cwe_table_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cwe_table_ram #(
   parameter int TABLE_DEPTH = cwe_pkg::TABLE_DEPTH
) (
   input  wire logic                      clock,
   input  wire cwe_pkg::tbl_req_type      tbl_req,
   output logic [cwe_pkg::CharW-1:0]      rd_data
);

   localparam int AddrW = $clog2(TABLE_DEPTH);

   logic [cwe_pkg::CharW-1:0] mem [TABLE_DEPTH];
   logic [cwe_pkg::CharW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr[AddrW-1:0]] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.rd_addr[AddrW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/cwe_walker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cwe_walker #(
   parameter int MAX_WORD_LEN = cwe_pkg::MAX_WORD_LEN,
   parameter int TABLE_DEPTH  = cwe_pkg::TABLE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire cwe_pkg::req_type          req_data,
   input  wire cwe_pkg::cfg_type          cfg,
   input  wire logic [cwe_pkg::CharW-1:0] tbl_rd_data,
   output cwe_pkg::tbl_req_type           tbl_req,
   output logic                           busy,
   output logic                           rsp_valid,
   output cwe_pkg::rsp_type               rsp_data
);

   localparam int PosW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam logic [cwe_pkg::LenW-1:0]  MaxLen     = cwe_pkg::LenW'(MAX_WORD_LEN);
   localparam logic [cwe_pkg::SizeW-1:0] TableDepth = cwe_pkg::SizeW'(TABLE_DEPTH);

   cwe_pkg::walk_state_type state_ff, state_in;

   logic [cwe_pkg::LenW-1:0]   len_ff, len_in;
   logic [cwe_pkg::DigitW-1:0] digit_ff [MAX_WORD_LEN];
   logic [cwe_pkg::DigitW-1:0] digit_in [MAX_WORD_LEN];
   logic [cwe_pkg::CharW-1:0]  char_ff  [MAX_WORD_LEN];
   logic [cwe_pkg::CharW-1:0]  char_in  [MAX_WORD_LEN];
   logic [cwe_pkg::CountW-1:0] words_ff, words_in;
   logic                       started_ff, started_in;
   logic                       finished_ff, finished_in;
   logic [PosW-1:0]            fill_pos_ff, fill_pos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cwe_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic [cwe_pkg::SizeW-1:0]  size_eff;
   logic [cwe_pkg::LenW-1:0]   maxl;
   logic [cwe_pkg::LenW-1:0]   minl;
   logic                       limit_hit;
   logic [cwe_pkg::LenW-1:0]   top_pos;
   logic [cwe_pkg::DigitW-1:0] top_digit;
   logic [cwe_pkg::SizeW-1:0]  digit_inc;
   logic                       tbl_write;
   logic [cwe_pkg::WordW-1:0]  word_next;

   // Effective bounds from the raw register values.
   assign size_eff  = (cfg.charset_size > TableDepth) ? TableDepth : cfg.charset_size;
   assign minl      = (cfg.min_length == '0) ? cwe_pkg::LenW'(1) : cfg.min_length;
   assign limit_hit = cfg.limit_enable && (words_ff >= cfg.line_limit);
   assign top_pos   = len_ff - cwe_pkg::LenW'(1);
   assign top_digit = digit_ff[top_pos[PosW-1:0]];
   assign digit_inc = {1'b0, top_digit} + cwe_pkg::SizeW'(1);
   assign tbl_write = start && (state_ff == cwe_pkg::ST_IDLE) &&
                      (req_data.func == cwe_pkg::FUNC_WRITE) &&
                      ({1'b0, req_data.entry_index} < TableDepth);

   always_comb begin
      if (cfg.max_length == '0) begin
         maxl = cwe_pkg::LenW'(1);
      end else if (cfg.max_length > MaxLen) begin
         maxl = MaxLen;
      end else begin
         maxl = cfg.max_length;
      end
   end

   // Pack the character stack; bytes at or past the length read as zero.
   for (genvar i = 0; i < cwe_pkg::WordBytes; i++) begin : g_pack
      if (i < MAX_WORD_LEN) begin : g_used
         assign word_next[i*cwe_pkg::CharW +: cwe_pkg::CharW] =
            (cwe_pkg::LenW'(i) < len_ff) ? char_in[i] : '0;
      end else begin : g_zero
         assign word_next[i*cwe_pkg::CharW +: cwe_pkg::CharW] = '0;
      end
   end

   always_comb begin
      logic exhaust;
      logic carry_step;

      exhaust      = 1'b0;
      carry_step   = 1'b0;
      state_in     = state_ff;
      len_in       = len_ff;
      digit_in     = digit_ff;
      char_in      = char_ff;
      words_in     = words_ff;
      started_in   = started_ff;
      finished_in  = finished_ff;
      fill_pos_in  = fill_pos_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      tbl_req      = '0;

      // Keep cached characters coherent with table writes.
      if (tbl_write) begin
         tbl_req.wr_en   = 1'b1;
         tbl_req.wr_addr = req_data.entry_index;
         tbl_req.wr_data = req_data.entry_char;
         for (int i = 0; i < MAX_WORD_LEN; i++) begin
            if (digit_ff[i] == req_data.entry_index) begin
               char_in[i] = req_data.entry_char;
            end
         end
      end

      unique case (state_ff)
         cwe_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_data.func)
                  cwe_pkg::FUNC_NEXT: begin
                     if (finished_ff || (minl > maxl) || limit_hit) begin
                        exhaust = 1'b1;
                     end else begin
                        state_in = cwe_pkg::ST_ADV;
                     end
                  end
                  cwe_pkg::FUNC_RESTART: begin
                     len_in      = '0;
                     words_in    = '0;
                     started_in  = 1'b0;
                     finished_in = 1'b0;
                     for (int i = 0; i < MAX_WORD_LEN; i++) begin
                        digit_in[i] = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         cwe_pkg::ST_ADV: begin
            if (!started_ff) begin
               if (size_eff == '0) begin
                  exhaust = 1'b1;
               end else begin
                  started_in    = 1'b1;
                  digit_in[0]   = '0;
                  len_in        = cwe_pkg::LenW'(1);
                  tbl_req.rd_en = 1'b1;
                  fill_pos_in   = '0;
                  state_in      = cwe_pkg::ST_FILL;
               end
            end else if (len_ff < maxl) begin
               digit_in[len_ff[PosW-1:0]] = '0;
               len_in        = len_ff + cwe_pkg::LenW'(1);
               tbl_req.rd_en = 1'b1;
               fill_pos_in   = len_ff[PosW-1:0];
               state_in      = cwe_pkg::ST_FILL;
            end else begin
               carry_step = 1'b1;
            end
         end
         cwe_pkg::ST_CARRY: begin
            carry_step = 1'b1;
         end
         cwe_pkg::ST_FILL: begin
            char_in[fill_pos_ff] = tbl_rd_data;
            if (len_ff >= minl) begin
               words_in             = words_ff + cwe_pkg::CountW'(1);
               rsp_valid_in         = 1'b1;
               rsp_data_in.word     = word_next;
               rsp_data_in.word_len = len_ff;
               rsp_data_in.exhausted = 1'b0;
               state_in             = cwe_pkg::ST_IDLE;
            end else begin
               state_in = cwe_pkg::ST_ADV;
            end
         end
         default: begin
            state_in = cwe_pkg::ST_IDLE;
         end
      endcase

      // Advance the last index, or drop it and move the carry left.
      if (carry_step) begin
         if (digit_inc < size_eff) begin
            digit_in[top_pos[PosW-1:0]] = digit_inc[cwe_pkg::DigitW-1:0];
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = digit_inc[cwe_pkg::DigitW-1:0];
            fill_pos_in     = top_pos[PosW-1:0];
            state_in        = cwe_pkg::ST_FILL;
         end else begin
            len_in = top_pos;
            if (top_pos == '0) begin
               exhaust = 1'b1;
            end else begin
               state_in = cwe_pkg::ST_CARRY;
            end
         end
      end

      if (exhaust) begin
         finished_in  = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{word: '0, word_len: '0, exhausted: 1'b1};
         state_in     = cwe_pkg::ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cwe_pkg::ST_IDLE;
         len_ff       <= '0;
         words_ff     <= '0;
         started_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_WORD_LEN; i++) begin
            digit_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         words_ff     <= words_in;
         started_ff   <= started_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         digit_ff     <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      fill_pos_ff <= fill_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != cwe_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_exhausted_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.exhausted |->
         rsp_data_ff.word == '0 && rsp_data_ff.word_len == '0)
      else $error("exhausted result carries a word");

   a_word_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.exhausted |->
         rsp_data_ff.word_len != '0 && rsp_data_ff.word_len <= MaxLen)
      else $error("word length out of range");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= MaxLen)
      else $error("odometer grew past the stack depth");

   a_fill_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == cwe_pkg::ST_FILL |->
         $past(state_ff) == cwe_pkg::ST_ADV || $past(state_ff) == cwe_pkg::ST_CARRY)
      else $error("fill without a table read");

endmodule

`default_nettype wire

@@ src/charset_word_enumerator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Brute-force word generator. Load the character table with write transfers
// (func 0), then each next-word transfer (func 1) returns one candidate word,
// walking all strings over the table from min_length to max_length in
// depth-first order; a restart transfer (func 2) rewinds the walk. A request
// is taken when start is high and busy is low; its result shows on rsp_data
// for exactly one cycle with rsp_valid high, and the receiver cannot stall
// it, so sample it then. For a word the walker issues a table read, then
// fills the character stack and registers the result in its fill state; each
// index dropped in a carry passes through the carry state, each word skipped
// below min_length repeats advance and fill, and an exhausted answer found at
// the request is registered from idle. The pace is set by the single read
// port of the character table, whose read is registered. busy falls in the
// cycle rsp_valid rises, so the next request can overlap the strobe. Write
// the configuration registers only while busy is low.
module charset_word_enumerator #(
   parameter int MAX_WORD_LEN = cwe_pkg::MAX_WORD_LEN,
   parameter int TABLE_DEPTH  = cwe_pkg::TABLE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire cwe_pkg::req_type              req_data,
   output logic                               rsp_valid,
   output cwe_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [cwe_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [cwe_pkg::CsrDataW-1:0]  csr_wdata
);

   cwe_pkg::cfg_type         cfg_ff, cfg_in;
   cwe_pkg::tbl_req_type     tbl_req;
   logic [cwe_pkg::CharW-1:0] tbl_rd_data;

   // Decode register writes; indexes past the list drop the transfer.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            cwe_pkg::CSR_CHARSET_SIZE: cfg_in.charset_size = csr_wdata[cwe_pkg::SizeW-1:0];
            cwe_pkg::CSR_MIN_LENGTH:   cfg_in.min_length   = csr_wdata[cwe_pkg::LenW-1:0];
            cwe_pkg::CSR_MAX_LENGTH:   cfg_in.max_length   = csr_wdata[cwe_pkg::LenW-1:0];
            cwe_pkg::CSR_LIMIT_ENABLE: cfg_in.limit_enable = csr_wdata[0];
            cwe_pkg::CSR_LINE_LIMIT:   cfg_in.line_limit   = csr_wdata[cwe_pkg::CountW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{charset_size: '0,
                    min_length:   cwe_pkg::LenW'(1),
                    max_length:   cwe_pkg::LenW'(8),
                    limit_enable: 1'b0,
                    line_limit:   '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Odometer, skip and carry sequencer; holds the cached characters.
   cwe_walker #(
      .MAX_WORD_LEN (MAX_WORD_LEN),
      .TABLE_DEPTH  (TABLE_DEPTH)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .tbl_rd_data (tbl_rd_data),
      .tbl_req     (tbl_req),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // Character table: one write and one registered read per cycle.
   cwe_table_ram #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import cwe_pkg::*;

   // The fourth function code has no meaning in the block; send it as noise.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Cycles to let pass after the last result before touching the CSRs. Skipped
   // words and dropped indices can keep the block busy.
   localparam int DRAIN_CYCLES = 64;
   // Cycles without any transfer on either channel before the run is abandoned.
   localparam int STALL_LIMIT  = 4000;
   // Stop printing mismatch lines after this many; keep counting.
   localparam int MAX_REPORTS  = 40;

   typedef enum logic [1:0] {
      ROW_CFG,
      ROW_REQ,
      ROW_REQ_TYPED
   } row_kind_e;

   // One line of the directed table: a CSR setting, a request transfer, or a
   // request transfer whose answer is typed in by hand.
   typedef struct packed {
      row_kind_e kind;
      cfg_type   cfg;
      req_type   req;
      rsp_type   want;
   } stim_row_t;

   // One random phase: register setting, whether to rewind first, how often
   // the sender idles, and how many request transfers to issue.
   typedef struct packed {
      cfg_type cfg;
      bit      rewind;
      int      idle_pct;
      int      items;
   } phase_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_wdata = '0;

   charset_word_enumerator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Shadow of the block: character memory, odometer and walk flags, plus the
   // register values as last programmed.
   // ---------------------------------------------------------------------------
   logic [CharW-1:0]  glyphs [TABLE_DEPTH];
   logic [DigitW-1:0] odometer [MAX_WORD_LEN];
   int unsigned       odo_len;
   logic [CountW-1:0] words_given;
   bit                walk_open;
   bit                walk_done;
   cfg_type           csr_shadow;

   rsp_type           pending_words[$];

   int mismatches;
   int items_sent;
   int results_seen;
   int words_seen;
   int exhausted_seen;
   int settings_used;
   int quiet_cycles;

   stim_row_t directed[$];
   phase_t    phases[$];

   initial begin
      forever #1 clock = ~clock;
   end

   // Rewind the walk; the table and the registers stay as they are.
   function automatic void rewind_walk();
      foreach (odometer[i]) odometer[i] = '0;
      odo_len     = 0;
      words_given = '0;
      walk_open   = 1'b0;
      walk_done   = 1'b0;
   endfunction

   // Step the odometer to the next word in depth-first preorder: extend with
   // the first character while there is room, else bump the last index and
   // carry left, dropping positions that run off the table.
   function automatic bit step_odometer(input int unsigned sz, input int unsigned maxl);
      if (!walk_open) begin
         if (sz == 0) return 1'b0;
         walk_open   = 1'b1;
         odometer[0] = '0;
         odo_len     = 1;
         return 1'b1;
      end
      if (odo_len < maxl) begin
         odometer[odo_len] = '0;
         odo_len++;
         return 1'b1;
      end
      while (odo_len > 0) begin
         if (int'(odometer[odo_len-1]) + 1 < sz) begin
            odometer[odo_len-1]++;
            return 1'b1;
         end
         odo_len--;
      end
      return 1'b0;
   endfunction

   // Work out the answer to one next-word request and advance the shadow.
   function automatic rsp_type predict_next_word();
      int unsigned sz;
      int unsigned maxl;
      int unsigned minl;
      rsp_type     r;
      r    = '0;
      sz   = (csr_shadow.charset_size > TABLE_DEPTH) ? TABLE_DEPTH
                                                      : csr_shadow.charset_size;
      maxl = csr_shadow.max_length;
      if (maxl < 1) maxl = 1;
      if (maxl > MAX_WORD_LEN) maxl = MAX_WORD_LEN;
      minl = (csr_shadow.min_length == 0) ? 1 : csr_shadow.min_length;
      // Already finished, empty length window, or the line cap is reached.
      if (walk_done || minl > maxl ||
          (csr_shadow.limit_enable && words_given >= csr_shadow.line_limit)) begin
         walk_done   = 1'b1;
         r.exhausted = 1'b1;
         return r;
      end
      // Pass over words shorter than the minimum.
      forever begin
         if (!step_odometer(sz, maxl)) begin
            walk_done   = 1'b1;
            r.exhausted = 1'b1;
            return r;
         end
         if (odo_len >= minl) break;
      end
      for (int i = 0; i < odo_len; i++) r.word[CharW*i +: CharW] = glyphs[odometer[i]];
      r.word_len = LenW'(odo_len);
      words_given++;
      return r;
   endfunction

   // Apply one accepted request transfer to the shadow; queue the answer, or
   // the hand-typed one where the row carries it.
   function automatic void commit_item(input req_type r, input bit typed, input rsp_type want);
      rsp_type got;
      case (r.func)
         FUNC_WRITE: begin
            glyphs[r.entry_index] = r.entry_char;
         end
         FUNC_NEXT: begin
            got = predict_next_word();
            pending_words.push_back(typed ? want : got);
         end
         FUNC_RESTART: begin
            rewind_walk();
         end
         default: ;
      endcase
   endfunction

   function automatic cfg_type make_cfg(input int sz, input int minl, input int maxl,
                                        input bit lim_en, input logic [CountW-1:0] lim);
      cfg_type c;
      c.charset_size = SizeW'(sz);
      c.min_length   = LenW'(minl);
      c.max_length   = LenW'(maxl);
      c.limit_enable = lim_en;
      c.line_limit   = lim;
      return c;
   endfunction

   function automatic req_type make_req(input logic [1:0] func, input int idx, input int ch);
      req_type r;
      r.func        = func;
      r.entry_index = DigitW'(idx);
      r.entry_char  = CharW'(ch);
      return r;
   endfunction

   function automatic void add_cfg_row(input cfg_type c);
      stim_row_t s;
      s      = '0;
      s.kind = ROW_CFG;
      s.cfg  = c;
      directed.push_back(s);
   endfunction

   function automatic void add_req_row(input logic [1:0] func, input int idx, input int ch);
      stim_row_t s;
      s      = '0;
      s.kind = ROW_REQ;
      s.req  = make_req(func, idx, ch);
      directed.push_back(s);
   endfunction

   // A next-word request with its answer typed in.
   function automatic void add_word_row(input logic [WordW-1:0] word, input int len,
                                        input bit exh);
      stim_row_t s;
      s                = '0;
      s.kind           = ROW_REQ_TYPED;
      s.req            = make_req(FUNC_NEXT, 0, 0);
      s.want.word      = word;
      s.want.word_len  = LenW'(len);
      s.want.exhausted = exh;
      directed.push_back(s);
   endfunction

   function automatic void add_phase(input cfg_type c, input bit rewind, input int idle_pct,
                                     input int items);
      phase_t p;
      p.cfg      = c;
      p.rewind   = rewind;
      p.idle_pct = idle_pct;
      p.items    = items;
      phases.push_back(p);
   endfunction

   // Mostly next-word requests; some table writes, restarts and noise.
   function automatic req_type random_req();
      req_type     r;
      int unsigned pick;
      pick          = $urandom_range(99);
      r.entry_index = DigitW'($urandom);
      r.entry_char  = CharW'($urandom);
      if (pick < 88)      r.func = FUNC_NEXT;
      else if (pick < 94) r.func = FUNC_WRITE;
      else if (pick < 97) r.func = FUNC_RESTART;
      else                r.func = FUNC_UNUSED;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Compare one result transfer against the oldest queued answer.
   task automatic check_word(input rsp_type got);
      rsp_type exp;
      results_seen++;
      if (got.exhausted === 1'b1) exhausted_seen++;
      else words_seen++;
      if (pending_words.size() == 0) begin
         report_mismatch($sformatf("result %0d with nothing queued: word=%h len=%0d exh=%b",
                                   results_seen, got.word, got.word_len, got.exhausted));
         return;
      end
      exp = pending_words.pop_front();
      if (got.word !== exp.word)
         report_mismatch($sformatf("result %0d word: got %h want %h",
                                   results_seen, got.word, exp.word));
      if (got.word_len !== exp.word_len)
         report_mismatch($sformatf("result %0d word_len: got %0d want %0d",
                                   results_seen, got.word_len, exp.word_len));
      if (got.exhausted !== exp.exhausted)
         report_mismatch($sformatf("result %0d exhausted: got %b want %b",
                                   results_seen, got.exhausted, exp.exhausted));
   endtask

   // Drive one request transfer; idle the sender at random first, then hold
   // start until the block takes it. Leave start high on return: the caller
   // either sends the next transfer or drops start in the same step.
   task automatic send_transfer(input req_type r, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Drop start, wait for every queued answer and for busy to fall, then let
   // the block finish any work that has no result before CSRs are touched.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all five registers back to back, then release the write enable.
   task automatic program_csrs(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_CHARSET_SIZE;
      csr_wdata <= CsrDataW'(c.charset_size);
      @(posedge clock);
      csr_index <= CSR_MIN_LENGTH;
      csr_wdata <= CsrDataW'(c.min_length);
      @(posedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_wdata <= CsrDataW'(c.max_length);
      @(posedge clock);
      csr_index <= CSR_LIMIT_ENABLE;
      csr_wdata <= CsrDataW'(c.limit_enable);
      @(posedge clock);
      csr_index <= CSR_LINE_LIMIT;
      csr_wdata <= CsrDataW'(c.line_limit);
      @(posedge clock);
      csr_we     <= 1'b0;
      csr_shadow = c;
      settings_used++;
   endtask

   // Result monitor and watchdog. Results cannot be held off, so take every
   // strobe as a transfer; count cycles in which neither channel moves.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) check_word(rsp_data);
         if (rsp_valid || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d answers still queued",
                     quiet_cycles, pending_words.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      rsp_type no_word;
      no_word = '0;
      foreach (glyphs[i]) glyphs[i] = '0;
      rewind_walk();
      csr_shadow     = make_cfg(0, 1, 8, 1'b0, '0);
      mismatches     = 0;
      items_sent     = 0;
      results_seen   = 0;
      words_seen     = 0;
      exhausted_seen = 0;
      settings_used  = 0;
      quiet_cycles   = 0;

      // Directed table. Reset values leave an empty table: exhausted at once,
      // and it stays exhausted.
      add_word_row('0, 0, 1'b1);
      add_word_row('0, 0, 1'b1);
      // Load a few entries, extreme index and byte values; noise function.
      add_req_row(FUNC_WRITE, 0, 'h61);
      add_req_row(FUNC_WRITE, 1, 'hFF);
      add_req_row(FUNC_WRITE, 255, 'h00);
      add_req_row(FUNC_UNUSED, 255, 'hFF);
      add_word_row('0, 0, 1'b1);
      // Two characters, lengths one to two: the whole preorder walk, then done.
      add_cfg_row(make_cfg(2, 1, 2, 1'b0, '0));
      add_req_row(FUNC_RESTART, 0, 0);
      add_word_row(64'h61, 1, 1'b0);
      add_word_row(64'h6161, 2, 1'b0);
      add_word_row(64'hFF61, 2, 1'b0);
      add_word_row(64'hFF, 1, 1'b0);
      add_word_row(64'h61FF, 2, 1'b0);
      add_word_row(64'hFFFF, 2, 1'b0);
      add_word_row('0, 0, 1'b1);
      // Line cap of zero gives nothing.
      add_cfg_row(make_cfg(2, 1, 2, 1'b1, '0));
      add_req_row(FUNC_RESTART, 0, 0);
      add_word_row('0, 0, 1'b1);
      // Minimum above maximum gives nothing.
      add_cfg_row(make_cfg(2, 3, 2, 1'b0, '0));
      add_req_row(FUNC_RESTART, 0, 0);
      add_word_row('0, 0, 1'b1);
      // Zero minimum and zero maximum both clamp to one.
      add_cfg_row(make_cfg(2, 0, 0, 1'b0, '0));
      add_req_row(FUNC_RESTART, 0, 0);
      add_word_row(64'h61, 1, 1'b0);
      add_word_row(64'hFF, 1, 1'b0);
      add_word_row('0, 0, 1'b1);

      // Random phases; the whole table is loaded before the first one.
      add_phase(make_cfg(256, 1, 8, 1'b0, '0), 1'b1, 0, 140);
      add_phase(make_cfg(300, 8, 15, 1'b0, '0), 1'b1, 87, 80);
      add_phase(make_cfg(511, 0, 0, 1'b0, '0), 1'b1, 27, 300);
      add_phase(make_cfg(2, 1, 4, 1'b0, '0), 1'b1, 0, 80);
      add_phase(make_cfg(3, 2, 4, 1'b1, 40'd20), 1'b1, 87, 60);
      add_phase(make_cfg(1, 1, 8, 1'b0, '0), 1'b1, 27, 30);
      add_phase(make_cfg(0, 1, 8, 1'b0, '0), 1'b1, 0, 20);
      add_phase(make_cfg(4, 1, 3, 1'b1, 40'hFF_FFFF_FFFF), 1'b1, 0, 100);
      add_phase(make_cfg(5, 3, 3, 1'b0, '0), 1'b1, 87, 80);
      // Shrink the table and the length window in the middle of that walk.
      add_phase(make_cfg(2, 1, 2, 1'b0, '0), 1'b0, 27, 40);
      add_phase(make_cfg(8, 15, 8, 1'b0, '0), 1'b1, 0, 10);
      add_phase(make_cfg(16, 4, 6, 1'b1, 40'd50), 1'b1, 27, 80);
      add_phase(make_cfg(6, 2, 5, 1'b0, '0), 1'b1, 87, 150);

      // Hold reset, then release it for good.
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table back to back.
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CFG) begin
            settle();
            program_csrs(directed[i].cfg);
         end else begin
            send_transfer(directed[i].req, 0);
            commit_item(directed[i].req, directed[i].kind == ROW_REQ_TYPED,
                        directed[i].want);
         end
      end

      // Fill every table entry with a random byte so any size can be read.
      for (int idx = 0; idx < TABLE_DEPTH; idx++) begin
         req_type w;
         w = make_req(FUNC_WRITE, idx, $urandom_range(255));
         send_transfer(w, 27);
         commit_item(w, 1'b0, no_word);
      end

      foreach (phases[p]) begin
         settle();
         program_csrs(phases[p].cfg);
         if (phases[p].rewind) begin
            req_type rw;
            rw = make_req(FUNC_RESTART, $urandom_range(255), $urandom_range(255));
            send_transfer(rw, phases[p].idle_pct);
            commit_item(rw, 1'b0, no_word);
         end
         for (int n = 0; n < phases[p].items; n++) begin
            req_type r;
            r = random_req();
            send_transfer(r, phases[p].idle_pct);
            commit_item(r, 1'b0, no_word);
         end
      end

      // Drain: every queued answer must arrive; the watchdog bounds the wait.
      settle();

      $display("covered %0d request transfers under %0d register settings",
               items_sent, settings_used);
      $display("checked %0d words and %0d exhausted answers; %0d field mismatches",
               words_seen, exhausted_seen, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ charset_word_enumerator.f @@
src/cwe_pkg.sv
src/cwe_table_ram.sv
src/cwe_walker.sv
src/charset_word_enumerator.sv
tb/sv/testbench.sv
